[rtl/psd_pkg.sv]
// Package: shared constant (T_BITS) and region codes for the point to segment distance unit.
package psd_pkg;

    localparam int T_BITS = 32;

    typedef enum logic [1:0]
    {
        REGION_DEGEN    = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2,
        REGION_INTERIOR = 2'd3
    } region_t;

endpackage

[rtl/psd_in_if.sv]
// Interface: query word channel (point and segment end points).
interface psd_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    input ready);
    modport sink   (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    output ready);
endinterface

[rtl/psd_out_if.sv]
// Interface: result word channel (distance, closest point, region).
interface psd_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic        [COORD_WIDTH:0]   distance;
    logic signed [COORD_WIDTH-1:0] closest_x;
    logic signed [COORD_WIDTH-1:0] closest_y;
    psd_pkg::region_t              region;

    modport source (output valid, distance, closest_x, closest_y, region, input ready);
    modport sink   (input valid, distance, closest_x, closest_y, region, output ready);
endinterface

[rtl/point_segment_distance_unit.sv]
// Point to segment distance: fully pipelined, one word per cycle.
// The pipeline holds the one-bit-per-stage divider and the one-bit-per-stage
// square root.
// Throughput: one word per cycle; a stall on the result side freezes every stage.
// Reset clears the stage valid bits only; no stored state between words.
module point_segment_distance_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    psd_in_if.sink     query,
    psd_out_if.source  result
);
    localparam int W   = COORD_WIDTH;
    localparam int D1  = W + 1;
    localparam int PW  = 2 * D1;
    localparam int DW  = PW + 1;
    localparam int T   = psd_pkg::T_BITS;
    localparam int MW  = D1 + T;
    localparam int RB  = W + 2;
    localparam int SW  = 2 * RB;
    localparam int LAT = 10 + T + RB;

    function automatic logic signed [D1-1:0] ext(input logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic [D1-1:0] mag(input logic signed [D1-1:0] v);
        logic signed [D1-1:0] n;
        n = -v;
        return v[D1-1] ? n : v;
    endfunction

    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv          = !vld_reg[LAT-1] || result.ready;
    assign query.ready  = adv;
    assign result.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], query.valid};
        end
    end

    // stage 1: differences
    logic signed [D1-1:0] a_dx_reg, a_dy_reg, a_ux_reg, a_uy_reg;
    logic signed [W-1:0]  a_px_reg, a_py_reg, a_sx_reg, a_sy_reg, a_ex_reg, a_ey_reg;
    // stage 2: products
    logic [PW-1:0]        b_dxx_reg, b_dyy_reg, b_tx_reg, b_ty_reg;
    logic                 b_xneg_reg, b_yneg_reg;
    logic signed [D1-1:0] b_dx_reg, b_dy_reg;
    logic signed [W-1:0]  b_px_reg, b_py_reg, b_sx_reg, b_sy_reg, b_ex_reg, b_ey_reg;
    // stage 3: sums
    logic [DW-1:0]        c_dsq_reg, c_pos_reg, c_neg_reg;
    logic signed [D1-1:0] c_dx_reg, c_dy_reg;
    logic signed [W-1:0]  c_px_reg, c_py_reg, c_sx_reg, c_sy_reg, c_ex_reg, c_ey_reg;
    // stage 4: dot product and early flags
    logic [DW-1:0]        e_dsq_reg, e_dot_reg;
    logic                 e_degen_reg, e_before_reg;
    logic signed [D1-1:0] e_dx_reg, e_dy_reg;
    logic signed [W-1:0]  e_px_reg, e_py_reg, e_sx_reg, e_sy_reg, e_ex_reg, e_ey_reg;

    // divider stages, index 0 is the region decision stage
    logic [DW-1:0]        dv_r_reg   [0:T];
    logic [T-1:0]         dv_t_reg   [0:T];
    logic [DW-1:0]        dv_dsq_reg [0:T];
    logic                 dv_full_reg[0:T];
    psd_pkg::region_t     dv_reg_reg [0:T];
    logic signed [D1-1:0] dv_dx_reg  [0:T];
    logic signed [D1-1:0] dv_dy_reg  [0:T];
    logic signed [W-1:0]  dv_px_reg  [0:T];
    logic signed [W-1:0]  dv_py_reg  [0:T];
    logic signed [W-1:0]  dv_sx_reg  [0:T];
    logic signed [W-1:0]  dv_sy_reg  [0:T];
    logic signed [W-1:0]  dv_ex_reg  [0:T];
    logic signed [W-1:0]  dv_ey_reg  [0:T];
    logic [DW-1:0]        dv_r_next  [0:T-1];
    logic                 dv_ge_next [0:T-1];

    always_comb
    begin
        for (int k = 0; k < T; k++)
        begin
            logic [DW:0] r2;
            r2 = {dv_r_reg[k], 1'b0};
            dv_ge_next[k] = r2 >= {1'b0, dv_dsq_reg[k]};
            dv_r_next[k]  = dv_ge_next[k] ? DW'(r2 - {1'b0, dv_dsq_reg[k]}) : DW'(r2);
        end
    end

    // stage M: scale by t
    logic [MW-1:0]        m_xp_reg, m_yp_reg;
    logic                 m_xneg_reg, m_yneg_reg;
    psd_pkg::region_t     m_region_reg;
    logic signed [W-1:0]  m_px_reg, m_py_reg, m_sx_reg, m_sy_reg, m_ex_reg, m_ey_reg;
    // stage G: closest point
    logic signed [W-1:0]  g_cx_reg, g_cy_reg, g_px_reg, g_py_reg;
    psd_pkg::region_t     g_region_reg;
    // stage H: offset to closest point
    logic signed [D1-1:0] h_qx_reg, h_qy_reg;
    logic signed [W-1:0]  h_cx_reg, h_cy_reg;
    psd_pkg::region_t     h_region_reg;
    // stage I: squares
    logic [PW-1:0]        i_qxx_reg, i_qyy_reg;
    logic signed [W-1:0]  i_cx_reg, i_cy_reg;
    psd_pkg::region_t     i_region_reg;

    // square root stages, index 0 holds the squared distance
    logic [SW-1:0]        sq_rem_reg [0:RB];
    logic [RB-1:0]        sq_root_reg[0:RB];
    logic signed [W-1:0]  sq_cx_reg  [0:RB];
    logic signed [W-1:0]  sq_cy_reg  [0:RB];
    psd_pkg::region_t     sq_reg_reg [0:RB];
    logic [SW-1:0]        sq_rem_next [0:RB-1];
    logic [RB-1:0]        sq_root_next[0:RB-1];

    always_comb
    begin
        for (int j = 0; j < RB; j++)
        begin
            logic [SW-1:0] delta;
            logic [RB-1:0] bit_m;
            delta = (SW'(sq_root_reg[j]) << (RB - j)) | (SW'(1) << (2 * (RB - 1 - j)));
            bit_m = RB'(1) << (RB - 1 - j);
            if (sq_rem_reg[j] >= delta)
            begin
                sq_rem_next[j]  = sq_rem_reg[j] - delta;
                sq_root_next[j] = sq_root_reg[j] | bit_m;
            end
            else
            begin
                sq_rem_next[j]  = sq_rem_reg[j];
                sq_root_next[j] = sq_root_reg[j];
            end
        end
    end

    logic [D1-1:0]        g_qx, g_qy;
    logic                 g_rx, g_ry;
    logic signed [W+2:0]  g_offx, g_offy, g_sumx, g_sumy;
    logic [T:0]           m_t;

    always_comb
    begin
        m_t = dv_full_reg[T] ? ((T+1)'(1) << T) : {1'b0, dv_t_reg[T]};
        g_qx = m_xp_reg[MW-1:T];
        g_qy = m_yp_reg[MW-1:T];
        g_rx = |m_xp_reg[T-1:0];
        g_ry = |m_yp_reg[T-1:0];
        g_offx = m_xneg_reg ? -($signed({2'b00, g_qx}) + (W+3)'(g_rx))
                            : $signed({2'b00, g_qx});
        g_offy = m_yneg_reg ? -($signed({2'b00, g_qy}) + (W+3)'(g_ry))
                            : $signed({2'b00, g_qy});
        g_sumx = (W+3)'(m_sx_reg) + g_offx;
        g_sumy = (W+3)'(m_sy_reg) + g_offy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg <= ext(query.end_x) - ext(query.start_x);
            a_dy_reg <= ext(query.end_y) - ext(query.start_y);
            a_ux_reg <= ext(query.point_x) - ext(query.start_x);
            a_uy_reg <= ext(query.point_y) - ext(query.start_y);
            a_px_reg <= query.point_x;
            a_py_reg <= query.point_y;
            a_sx_reg <= query.start_x;
            a_sy_reg <= query.start_y;
            a_ex_reg <= query.end_x;
            a_ey_reg <= query.end_y;

            b_dxx_reg  <= PW'(mag(a_dx_reg)) * PW'(mag(a_dx_reg));
            b_dyy_reg  <= PW'(mag(a_dy_reg)) * PW'(mag(a_dy_reg));
            b_tx_reg   <= PW'(mag(a_ux_reg)) * PW'(mag(a_dx_reg));
            b_ty_reg   <= PW'(mag(a_uy_reg)) * PW'(mag(a_dy_reg));
            b_xneg_reg <= a_ux_reg[D1-1] != a_dx_reg[D1-1];
            b_yneg_reg <= a_uy_reg[D1-1] != a_dy_reg[D1-1];
            b_dx_reg <= a_dx_reg;  b_dy_reg <= a_dy_reg;
            b_px_reg <= a_px_reg;  b_py_reg <= a_py_reg;
            b_sx_reg <= a_sx_reg;  b_sy_reg <= a_sy_reg;
            b_ex_reg <= a_ex_reg;  b_ey_reg <= a_ey_reg;

            c_dsq_reg <= DW'(b_dxx_reg) + DW'(b_dyy_reg);
            c_pos_reg <= (b_xneg_reg ? DW'(0) : DW'(b_tx_reg))
                       + (b_yneg_reg ? DW'(0) : DW'(b_ty_reg));
            c_neg_reg <= (b_xneg_reg ? DW'(b_tx_reg) : DW'(0))
                       + (b_yneg_reg ? DW'(b_ty_reg) : DW'(0));
            c_dx_reg <= b_dx_reg;  c_dy_reg <= b_dy_reg;
            c_px_reg <= b_px_reg;  c_py_reg <= b_py_reg;
            c_sx_reg <= b_sx_reg;  c_sy_reg <= b_sy_reg;
            c_ex_reg <= b_ex_reg;  c_ey_reg <= b_ey_reg;

            e_dsq_reg    <= c_dsq_reg;
            e_dot_reg    <= c_pos_reg - c_neg_reg;
            e_degen_reg  <= c_dsq_reg == '0;
            e_before_reg <= c_neg_reg > c_pos_reg;
            e_dx_reg <= c_dx_reg;  e_dy_reg <= c_dy_reg;
            e_px_reg <= c_px_reg;  e_py_reg <= c_py_reg;
            e_sx_reg <= c_sx_reg;  e_sy_reg <= c_sy_reg;
            e_ex_reg <= c_ex_reg;  e_ey_reg <= c_ey_reg;

            if (e_degen_reg)
                dv_reg_reg[0] <= psd_pkg::REGION_DEGEN;
            else if (e_before_reg)
                dv_reg_reg[0] <= psd_pkg::REGION_START;
            else if (e_dot_reg > e_dsq_reg)
                dv_reg_reg[0] <= psd_pkg::REGION_END;
            else
                dv_reg_reg[0] <= psd_pkg::REGION_INTERIOR;
            dv_full_reg[0] <= e_dot_reg == e_dsq_reg;
            dv_r_reg[0]    <= e_dot_reg;
            dv_t_reg[0]    <= '0;
            dv_dsq_reg[0]  <= e_dsq_reg;
            dv_dx_reg[0] <= e_dx_reg;  dv_dy_reg[0] <= e_dy_reg;
            dv_px_reg[0] <= e_px_reg;  dv_py_reg[0] <= e_py_reg;
            dv_sx_reg[0] <= e_sx_reg;  dv_sy_reg[0] <= e_sy_reg;
            dv_ex_reg[0] <= e_ex_reg;  dv_ey_reg[0] <= e_ey_reg;

            for (int k = 0; k < T; k++)
            begin
                dv_r_reg[k+1]    <= dv_r_next[k];
                dv_t_reg[k+1]    <= {dv_t_reg[k][T-2:0], dv_ge_next[k]};
                dv_dsq_reg[k+1]  <= dv_dsq_reg[k];
                dv_full_reg[k+1] <= dv_full_reg[k];
                dv_reg_reg[k+1]  <= dv_reg_reg[k];
                dv_dx_reg[k+1] <= dv_dx_reg[k];  dv_dy_reg[k+1] <= dv_dy_reg[k];
                dv_px_reg[k+1] <= dv_px_reg[k];  dv_py_reg[k+1] <= dv_py_reg[k];
                dv_sx_reg[k+1] <= dv_sx_reg[k];  dv_sy_reg[k+1] <= dv_sy_reg[k];
                dv_ex_reg[k+1] <= dv_ex_reg[k];  dv_ey_reg[k+1] <= dv_ey_reg[k];
            end

            m_xp_reg     <= MW'(mag(dv_dx_reg[T])) * MW'(m_t);
            m_yp_reg     <= MW'(mag(dv_dy_reg[T])) * MW'(m_t);
            m_xneg_reg   <= dv_dx_reg[T][D1-1];
            m_yneg_reg   <= dv_dy_reg[T][D1-1];
            m_region_reg <= dv_reg_reg[T];
            m_px_reg <= dv_px_reg[T];  m_py_reg <= dv_py_reg[T];
            m_sx_reg <= dv_sx_reg[T];  m_sy_reg <= dv_sy_reg[T];
            m_ex_reg <= dv_ex_reg[T];  m_ey_reg <= dv_ey_reg[T];

            case (m_region_reg)
                psd_pkg::REGION_INTERIOR:
                begin
                    g_cx_reg <= g_sumx[W-1:0];
                    g_cy_reg <= g_sumy[W-1:0];
                end
                psd_pkg::REGION_END:
                begin
                    g_cx_reg <= m_ex_reg;
                    g_cy_reg <= m_ey_reg;
                end
                default:
                begin
                    g_cx_reg <= m_sx_reg;
                    g_cy_reg <= m_sy_reg;
                end
            endcase
            g_region_reg <= m_region_reg;
            g_px_reg <= m_px_reg;  g_py_reg <= m_py_reg;

            h_qx_reg <= ext(g_px_reg) - ext(g_cx_reg);
            h_qy_reg <= ext(g_py_reg) - ext(g_cy_reg);
            h_cx_reg <= g_cx_reg;  h_cy_reg <= g_cy_reg;
            h_region_reg <= g_region_reg;

            i_qxx_reg <= PW'(mag(h_qx_reg)) * PW'(mag(h_qx_reg));
            i_qyy_reg <= PW'(mag(h_qy_reg)) * PW'(mag(h_qy_reg));
            i_cx_reg <= h_cx_reg;  i_cy_reg <= h_cy_reg;
            i_region_reg <= h_region_reg;

            sq_rem_reg[0]  <= SW'(i_qxx_reg) + SW'(i_qyy_reg);
            sq_root_reg[0] <= '0;
            sq_cx_reg[0]   <= i_cx_reg;
            sq_cy_reg[0]   <= i_cy_reg;
            sq_reg_reg[0]  <= i_region_reg;

            for (int j = 0; j < RB; j++)
            begin
                sq_rem_reg[j+1]  <= sq_rem_next[j];
                sq_root_reg[j+1] <= sq_root_next[j];
                sq_cx_reg[j+1]   <= sq_cx_reg[j];
                sq_cy_reg[j+1]   <= sq_cy_reg[j];
                sq_reg_reg[j+1]  <= sq_reg_reg[j];
            end
        end
    end

    assign result.distance  = sq_root_reg[RB][W:0];
    assign result.closest_x = sq_cx_reg[RB];
    assign result.closest_y = sq_cy_reg[RB];
    assign result.region    = sq_reg_reg[RB];

endmodule

[tb/point_segment_distance_unit_tb.sv]
// Testbench: random and directed point to segment queries checked against a behavioural predictor.
`timescale 1ns / 100ps

module point_segment_distance_unit_tb;

    localparam int CW = 32;
    localparam int N_RANDOM = 1430;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [CW-1:0] px, py, sx, sy, ex, ey;
    } query_t;

    typedef struct packed {
        logic [CW:0]          distance;
        logic signed [CW-1:0] cx, cy;
        psd_pkg::region_t     reg_code;
    } answer_t;

    // floor(sqrt(n)) for up to 128-bit n
    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    // floor(d * t / 2^T_BITS)
    function automatic logic signed [127:0] scale_floor(logic signed [63:0] d,
                                                        logic [63:0] t);
        logic signed [127:0] p;
        p = $signed({{64{d[63]}}, d}) * $signed({64'd0, t});
        return p >>> psd_pkg::T_BITS;
    endfunction

    function automatic answer_t project_point(query_t q);
        answer_t a;
        logic signed [63:0]  dx, dy, ux, uy, cx, cy, qx, qy;
        logic signed [127:0] dsq, dot, rem;
        logic [127:0]        d2;
        logic [63:0]         t;
        logic [63:0]         root;
        dx = 64'(q.ex) - 64'(q.sx);
        dy = 64'(q.ey) - 64'(q.sy);
        ux = 64'(q.px) - 64'(q.sx);
        uy = 64'(q.py) - 64'(q.sy);
        dsq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        dot = 128'(ux) * 128'(dx) + 128'(uy) * 128'(dy);
        if (dsq == 0)
        begin
            cx = 64'(q.sx); cy = 64'(q.sy); a.reg_code = psd_pkg::REGION_DEGEN;
        end
        else if (dot < 0)
        begin
            cx = 64'(q.sx); cy = 64'(q.sy); a.reg_code = psd_pkg::REGION_START;
        end
        else if (dot > dsq)
        begin
            cx = 64'(q.ex); cy = 64'(q.ey); a.reg_code = psd_pkg::REGION_END;
        end
        else
        begin
            if (dot == dsq)
                t = 64'd1 << psd_pkg::T_BITS;
            else
            begin
                t = '0;
                rem = dot;
                for (int i = 0; i < psd_pkg::T_BITS; i++)
                begin
                    rem = rem <<< 1;
                    t = t << 1;
                    if (rem >= dsq)
                    begin
                        rem = rem - dsq;
                        t[0] = 1'b1;
                    end
                end
            end
            cx = 64'(q.sx) + 64'(scale_floor(dx, t));
            cy = 64'(q.sy) + 64'(scale_floor(dy, t));
            a.reg_code = psd_pkg::REGION_INTERIOR;
        end
        qx = 64'(q.px) - cx;
        qy = 64'(q.py) - cy;
        d2 = 128'($signed(128'(qx)) * $signed(128'(qx)))
           + 128'($signed(128'(qy)) * $signed(128'(qy)));
        root = isqrt128(d2);
        a.distance = root[CW:0];
        a.cx = cx[CW-1:0];
        a.cy = cy[CW-1:0];
        return a;
    endfunction

    class distance_scoreboard;
        answer_t pending[$];
        int      mismatches;

        function void note_query(query_t q);
            pending.push_back(project_point(q));
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: distance=%h c=(%h,%h) reg=%0d",
                             got.distance, got.cx, got.cy, got.reg_code);
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance || got.cx !== want.cx || got.cy !== want.cy
                || got.reg_code !== want.reg_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: dist %h/%h cx %h/%h cy %h/%h reg %0d/%0d (exp/act)",
                             want.distance, got.distance, want.cx, got.cx, want.cy, got.cy,
                             want.reg_code, got.reg_code);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   idle_cycles = 0;
    bit   hold_off = 1'b0;
    bit   timed_out = 1'b0;
    distance_scoreboard sb = new();

    psd_in_if  #(.COORD_WIDTH(CW)) query ();
    psd_out_if #(.COORD_WIDTH(CW)) result ();

    point_segment_distance_unit #(.COORD_WIDTH(CW)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        query.valid = 1'b0;
        {query.point_x, query.point_y, query.start_x, query.start_y,
         query.end_x, query.end_y} = '0;
        result.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (query.valid && query.ready)
            sb.note_query({query.point_x, query.point_y, query.start_x, query.start_y,
                           query.end_x, query.end_y});
        if (result.valid && result.ready)
            sb.check_answer({result.distance, result.closest_x, result.closest_y,
                             result.region});
        if ((query.valid && query.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
            timed_out <= 1'b1;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 3);
            if (($urandom_range(0, 7) == 0) || gap == 0)
                result.ready <= 1'b1;
            else
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                result.ready <= 1'b1;
            end
        end
    end

    task automatic send_query(query_t q, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            query.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query.valid   <= 1'b1;
        query.point_x <= q.px;
        query.point_y <= q.py;
        query.start_x <= q.sx;
        query.start_y <= q.sy;
        query.end_x   <= q.ex;
        query.end_y   <= q.ey;
        do
            @(posedge clk);
        while (!query.ready);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return $signed(32'($urandom_range(0, 40))) - 20;
            2: return $signed($urandom()) >>> $urandom_range(0, 30);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        q.px = rand_coord(); q.py = rand_coord();
        q.sx = rand_coord(); q.sy = rand_coord();
        case ($urandom_range(0, 9))
            0:       begin q.ex = q.sx; q.ey = q.sy; end
            1:       begin q.ex = q.sx + $signed(32'($urandom_range(0, 6))) - 3;
                           q.ey = q.sy + $signed(32'($urandom_range(0, 6))) - 3; end
            2:       begin q.px = q.sx; q.py = q.sy; q.ex = rand_coord(); q.ey = rand_coord(); end
            default: begin q.ex = rand_coord(); q.ey = rand_coord(); end
        endcase
        return q;
    endfunction

    initial
    begin
        query_t directed[$];
        localparam logic signed [CW-1:0] MX = 32'sh7fffffff;
        localparam logic signed [CW-1:0] MN = 32'sh80000000;
        localparam logic signed [CW-1:0] ONE = 32'sh00010000;
        directed.push_back('{0, 0, 0, 0, 0, 0});
        directed.push_back('{MX, MX, MN, MN, MN, MN});
        directed.push_back('{MN, MN, MX, MX, MX, MX});
        directed.push_back('{-ONE, 0, 0, 0, ONE, 0});
        directed.push_back('{2 * ONE, ONE, 0, 0, ONE, 0});
        directed.push_back('{0, ONE, 0, 0, ONE, 0});
        directed.push_back('{ONE, ONE, 0, 0, ONE, 0});
        directed.push_back('{ONE / 3, 5, 0, 0, ONE, 0});
        directed.push_back('{MX, MN, MN, MN, MX, MX});
        directed.push_back('{MN, MX, MN, MN, MX, MX});
        directed.push_back('{0, 0, MN, MX, MX, MN});
        directed.push_back('{MX, MX, MN, MN, MX, MX});
        directed.push_back('{1, 1, 0, 0, 3, -7});
        directed.push_back('{-5, 2, -1, -1, 1, 1});
        directed.push_back('{32'shffffffff, 32'shffffffff, MX, MN, MN, MX});
        directed.push_back('{32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa,
                             32'sh55555555, 32'sh55555555, 32'shaaaaaaaa});
        directed.push_back('{MX, 0, 0, MX, MX, 0});
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_query(directed[i], 1'b0);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_off = 1'b1;
            if (n == 700)
            begin
                query.valid <= 1'b0;
                wait (sb.pending.size() == 0);
                @(posedge clk);
            end
            send_query(rand_query(), n >= 1000 && n < 1100);
        end
        query.valid <= 1'b0;
        wait (sb.pending.size() == 0 || timed_out);
        repeat (120) @(posedge clk);
        if (timed_out)
            $display("RESULT: ERROR");
        else if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
